### rtl/core/assert_macros.svh
// Assertion macros used by subpixel_antialiased_splat for its concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/sas_pkg.sv
// Package with the types, constants and codes of the antialiased splat block.
`timescale 1ns / 1ps

package sas_pkg;

	localparam int SAS_GRID_COLS = 16;
	localparam int SAS_GRID_ROWS = 16;

	localparam logic [7:0] CH_MAX = 8'hFF;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE  = 2'd2;

	localparam logic MODE_SPLAT = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WEIGHT,
		ST_RED,
		ST_GREEN,
		ST_BLUE,
		ST_READ,
		ST_RESP
	} sas_state_t;

	typedef enum logic {
		ALU_WEIGHT,
		ALU_SCALE_ADD
	} sas_alu_op_t;

	typedef struct packed {
		sas_alu_op_t op;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  base;
	} sas_alu_req_t;

endpackage

### rtl/core/sas_if.sv
// Valid/ready stream interfaces for splat items and pixel results.
`timescale 1ns / 1ps

interface sas_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [3:0]  read_column;
	logic [3:0]  read_row;

	modport source (output valid, mode, pos_x, pos_y, read_column, read_row, input ready);
	modport sink (input valid, mode, pos_x, pos_y, read_column, read_row, output ready);
endinterface

interface sas_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_red;
	logic [7:0] pixel_green;
	logic [7:0] pixel_blue;

	modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
	modport sink (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

### rtl/core/subpixel_antialiased_splat.sv
// Top level of the antialiased subpixel splat block with its frame store and sequencer.
//
// Usage:
// Items arrive on in_ch (valid/ready). A splat item (mode 0) adds the configured colour,
// weighted by four bilinear Wu weights, into the 2x2 pixels around pos_x/pos_y (8.8 fixed
// point); pixels off the grid are dropped and no result is produced. A read item (mode 1)
// returns the pixel at read_column/read_row on out_ch, or black when it lies off the grid.
// The user must write the colour registers through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce it. A splat occupies the block
// while it steps through WEIGHT, RED, GREEN and BLUE for each of its 2x2 pixels, on or
// off the grid, since one shared 8x8 multiplier forms the weight and then scales red,
// green and blue in turn around a read-modify-write of the frame store. A read occupies
// it through READ, where the frame store is read, and RESP, where the result is loaded
// into the output register once that register is free and then offered on out_ch. After
// reset the frame store is cleared one pixel per cycle, and no item is taken meanwhile;
// colours reset to white. A stalled receiver holds the result in the output register;
// splats carry on, and a further read waits until the pending result is transferred.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module subpixel_antialiased_splat
	import sas_pkg::*;
#(
	parameter int GRID_COLS = SAS_GRID_COLS,
	parameter int GRID_ROWS = SAS_GRID_ROWS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	sas_in_if.sink               in_ch,
	sas_out_if.source            out_ch
);

	localparam int DEPTH = GRID_COLS * GRID_ROWS;
	localparam int AW    = $clog2(DEPTH);

	sas_state_t state_q, state_d;

	logic [7:0]    color_red_q, color_green_q, color_blue_q;
	logic [AW-1:0] clr_q;
	logic [1:0]    corner_q;

	logic          mode_q;
	logic [15:0]   pos_x_q, pos_y_q;
	logic [3:0]    rc_q, rr_q;

	logic [7:0]    w_q;
	logic [7:0]    red_q, green_q;

	logic          out_valid_q;
	pixel_t        out_pix_q;

	logic          in_acc;
	logic          out_free;
	logic [8:0]    col_c, row_c;
	logic          corner_in_grid;
	logic          read_in_grid;
	logic [AW-1:0] corner_addr, read_addr;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	pixel_t        mem_wdata, rd_pix;

	sas_alu_req_t  alu_req;
	logic [7:0]    alu_res;

	function automatic logic [AW-1:0] pix_addr(input logic [8:0] col, input logic [8:0] row);
		return AW'(int'(row) * GRID_COLS + int'(col));
	endfunction

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;

	// Corner bit 0 steps the column, bit 1 the row; nine bits keep column 255 + 1 off grid.
	assign col_c = {1'b0, pos_x_q[15:8]} + 9'(corner_q[0]);
	assign row_c = {1'b0, pos_y_q[15:8]} + 9'(corner_q[1]);
	assign corner_in_grid = (col_c < 9'(GRID_COLS)) && (row_c < 9'(GRID_ROWS));
	assign read_in_grid   = ({5'b0, rc_q} < 9'(GRID_COLS)) && ({5'b0, rr_q} < 9'(GRID_ROWS));
	assign corner_addr = pix_addr(col_c, row_c);
	assign read_addr   = pix_addr({5'b0, rc_q}, {5'b0, rr_q});

	sas_frame_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(rd_pix)
	);

	sas_pixel_alu u_alu (
		.req   (alu_req),
		.result(alu_res)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (in_ch.mode == MODE_READ) ? ST_READ : ST_WEIGHT;
				end
			end
			ST_WEIGHT: state_d = ST_RED;
			ST_RED:    state_d = ST_GREEN;
			ST_GREEN:  state_d = ST_BLUE;
			ST_BLUE:   state_d = (corner_q == 2'd3) ? ST_IDLE : ST_WEIGHT;
			ST_READ:   state_d = ST_RESP;
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ch.ready = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = corner_addr;
		mem_wdata   = '{red: red_q, green: green_q, blue: alu_res};
		mem_re      = 1'b0;
		mem_raddr   = corner_addr;
		alu_req     = '{op: ALU_WEIGHT,
			a: corner_q[0] ? pos_x_q[7:0] : ~pos_x_q[7:0],
			b: corner_q[1] ? pos_y_q[7:0] : ~pos_y_q[7:0],
			base: 8'h00};
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				in_ch.ready = 1'b1;
			end
			ST_WEIGHT: begin
				mem_re = corner_in_grid;
			end
			ST_RED: begin
				alu_req = '{op: ALU_SCALE_ADD, a: color_red_q, b: w_q, base: rd_pix.red};
			end
			ST_GREEN: begin
				alu_req = '{op: ALU_SCALE_ADD, a: color_green_q, b: w_q, base: rd_pix.green};
			end
			ST_BLUE: begin
				alu_req = '{op: ALU_SCALE_ADD, a: color_blue_q, b: w_q, base: rd_pix.blue};
				mem_we  = corner_in_grid;
			end
			ST_READ: begin
				mem_re    = read_in_grid;
				mem_raddr = read_addr;
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			corner_q      <= '0;
			color_red_q   <= CH_MAX;
			color_green_q <= CH_MAX;
			color_blue_q  <= CH_MAX;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_IDLE) begin
				corner_q <= '0;
			end else if (state_q == ST_BLUE) begin
				corner_q <= corner_q + 2'd1;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_COLOR_RED:   color_red_q   <= cfg_data;
					REG_COLOR_GREEN: color_green_q <= cfg_data;
					REG_COLOR_BLUE:  color_blue_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item fields, working values and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q  <= in_ch.mode;
			pos_x_q <= in_ch.pos_x;
			pos_y_q <= in_ch.pos_y;
			rc_q    <= in_ch.read_column;
			rr_q    <= in_ch.read_row;
		end
		case (state_q)
			ST_WEIGHT: w_q     <= alu_res;
			ST_RED:    red_q   <= alu_res;
			ST_GREEN:  green_q <= alu_res;
			default: begin
			end
		endcase
		if (state_q == ST_RESP && out_free) begin
			out_pix_q <= read_in_grid ? rd_pix : '0;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.pixel_red   = out_pix_q.red;
	assign out_ch.pixel_green = out_pix_q.green;
	assign out_ch.pixel_blue  = out_pix_q.blue;

	// The frame store must never be written in a cycle in which it is read.
	`SAS_ASSERT_NOW(a_no_rw_overlap, clk, arst_n, mem_re, !mem_we, "frame store read and write overlap")

	// Only the clearing pass and the blue step of a splat write the frame store.
	`SAS_ASSERT_NOW(a_write_source, clk, arst_n, mem_we,
		(state_q == ST_CLEAR) || (state_q == ST_BLUE && mode_q == MODE_SPLAT),
		"unexpected frame store write")

	// A result appears only after the response step of a read item.
	`SAS_ASSERT_NOW(a_result_origin, clk, arst_n, $rose(out_valid_q),
		($past(state_q) == ST_RESP) && (mode_q == MODE_READ),
		"result without a read item")

endmodule

### rtl/core/sas_pixel_alu.sv
// Shared 8x8 multiply unit: forms a Wu weight or a scaled, saturating channel add.
`timescale 1ns / 1ps

module sas_pixel_alu
	import sas_pkg::*;
(
	input  sas_alu_req_t req,
	output logic [7:0]   result
);

	logic [15:0] prod;
	logic [15:0] weight_sum;
	logic [8:0]  chan_sum;

	assign prod = 16'(req.a) * 16'(req.b);

	// a*b + a + b peaks at 65535, so sixteen bits never overflow.
	assign weight_sum = prod + 16'(req.a) + 16'(req.b);
	assign chan_sum   = 9'(req.base) + 9'(prod[15:8]);

	always_comb begin
		case (req.op)
			ALU_WEIGHT:    result = weight_sum[15:8];
			ALU_SCALE_ADD: result = chan_sum[8] ? CH_MAX : chan_sum[7:0];
			default:       result = '0;
		endcase
	end

endmodule

### rtl/core/sas_frame_mem.sv
// Frame store memory: one write port and one registered read port.
`timescale 1ns / 1ps

module sas_frame_mem
	import sas_pkg::*;
#(
	parameter int DEPTH = SAS_GRID_COLS * SAS_GRID_ROWS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  pixel_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output pixel_t        rdata
);

	pixel_t mem [DEPTH];
	pixel_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### dv/sas_splat_checker.sv
// Checker that models the splat frame store and compares read results with the block's output.
`timescale 1ns / 1ps

module sas_splat_checker
	import sas_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	sas_in_if                    in_ch,
	sas_out_if                   out_ch,
	output int                   mismatches,
	output int                   outstanding
);

	localparam int PIXELS = SAS_GRID_COLS * SAS_GRID_ROWS;

	pixel_t splat_colour;
	pixel_t frame_img [PIXELS];
	pixel_t pixels_due [$];
	int     fail_count = 0;
	int     reads_due = 0;

	assign mismatches  = fail_count;
	assign outstanding = reads_due;

	function automatic logic [7:0] corner_weight(logic [7:0] a, logic [7:0] b);
		logic [15:0] acc;
		acc = a * b + a + b;
		return acc[15:8];
	endfunction

	function automatic logic [7:0] blend_channel(logic [7:0] stored, logic [7:0] colour,
			logic [7:0] w);
		logic [15:0] scaled;
		logic [8:0]  total;
		scaled = colour * w;
		total = stored + scaled[15:8];
		return total[8] ? CH_MAX : total[7:0];
	endfunction

	// Pixels that fall off the grid are simply dropped.
	task automatic deposit(int col, int row, logic [7:0] w);
		int idx;
		if (col >= SAS_GRID_COLS || row >= SAS_GRID_ROWS)
			return;
		idx = row * SAS_GRID_COLS + col;
		frame_img[idx].red   = blend_channel(frame_img[idx].red, splat_colour.red, w);
		frame_img[idx].green = blend_channel(frame_img[idx].green, splat_colour.green, w);
		frame_img[idx].blue  = blend_channel(frame_img[idx].blue, splat_colour.blue, w);
	endtask

	task automatic splat(logic [15:0] px, logic [15:0] py);
		logic [7:0] fx;
		logic [7:0] fy;
		int         col;
		int         row;
		fx = px[7:0];
		fy = py[7:0];
		col = px[15:8];
		row = py[15:8];
		deposit(col,     row,     corner_weight(CH_MAX - fx, CH_MAX - fy));
		deposit(col + 1, row,     corner_weight(fx, CH_MAX - fy));
		deposit(col,     row + 1, corner_weight(CH_MAX - fx, fy));
		deposit(col + 1, row + 1, corner_weight(fx, fy));
	endtask

	task automatic compare_channel(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t want;
		if (!arst_n) begin
			splat_colour = '{red: CH_MAX, green: CH_MAX, blue: CH_MAX};
			for (int i = 0; i < PIXELS; i++)
				frame_img[i] = '0;
			pixels_due.delete();
			reads_due <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COLOR_RED: begin
						splat_colour.red = cfg_data;
					end
					REG_COLOR_GREEN: begin
						splat_colour.green = cfg_data;
					end
					REG_COLOR_BLUE: begin
						splat_colour.blue = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (pixels_due.size() == 0) begin
					fail_count++;
					$display("%0t: result with no read outstanding, expected none, actual %h %h %h",
						$time, out_ch.pixel_red, out_ch.pixel_green, out_ch.pixel_blue);
				end else begin
					want = pixels_due.pop_front();
					compare_channel("red", want.red, out_ch.pixel_red);
					compare_channel("green", want.green, out_ch.pixel_green);
					compare_channel("blue", want.blue, out_ch.pixel_blue);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.mode == MODE_SPLAT)
					splat(in_ch.pos_x, in_ch.pos_y);
				else if (in_ch.read_column < SAS_GRID_COLS && in_ch.read_row < SAS_GRID_ROWS)
					pixels_due.push_back(
						frame_img[in_ch.read_row * SAS_GRID_COLS + in_ch.read_column]);
				else
					pixels_due.push_back('0);
			end
			reads_due <= pixels_due.size();
		end
	end

endmodule

### dv/tb_top.sv
// Top of the splat testbench: clock, reset, colour writes, item stimulus and the verdict.
`timescale 1ns / 1ps

module tb_top;
	import sas_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 24;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	int                   mismatches;
	int                   outstanding;
	bit                   send_steady = 1'b0;
	bit                   take_steady = 1'b0;
	int                   holds_asked = 0;
	int                   holds_done = 0;

	sas_in_if  in_ch ();
	sas_out_if out_ch ();

	subpixel_antialiased_splat dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	sas_splat_checker pixel_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Receiver: random back-pressure, plus long hold-offs on request so the block backs up.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_asked != holds_done) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
				out_ch.ready <= 1'b1;
			end else
				out_ch.ready <= take_steady || $urandom_range(99) >= 27;
		end
	end

	// Valid stays high across back-to-back transfers; it drops only for an idle gap.
	task automatic send_item(logic mode, logic [15:0] px, logic [15:0] py,
			logic [3:0] col, logic [3:0] row);
		if (!send_steady) begin
			while ($urandom_range(99) < 27) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_ch.valid       <= 1'b1;
		in_ch.mode        <= mode;
		in_ch.pos_x       <= px;
		in_ch.pos_y       <= py;
		in_ch.read_column <= col;
		in_ch.read_row    <= row;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic splat_at(logic [15:0] px, logic [15:0] py);
		send_item(MODE_SPLAT, px, py, 4'($urandom_range(15)), 4'($urandom_range(15)));
	endtask

	task automatic read_at(logic [3:0] col, logic [3:0] row);
		send_item(MODE_READ, 16'($urandom), 16'($urandom), col, row);
	endtask

	// A splat causes no result, so the block may still be busy with one once nothing is due.
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_colour(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		cfg_we    <= 1'b1;
		cfg_index <= REG_COLOR_RED;
		cfg_data  <= r;
		@(posedge clk);
		cfg_index <= REG_COLOR_GREEN;
		cfg_data  <= g;
		@(posedge clk);
		cfg_index <= REG_COLOR_BLUE;
		cfg_data  <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly on the grid or just past its edge, with a few far off it; fractions favour the extremes.
	function automatic logic [15:0] random_coord(int span);
		logic [7:0] whole;
		logic [7:0] frac;
		whole = ($urandom_range(99) < 85) ? 8'($urandom_range(span)) : 8'($urandom_range(255));
		case ($urandom_range(9))
			0: frac = 8'h00;
			1: frac = CH_MAX;
			default: frac = 8'($urandom_range(255));
		endcase
		return {whole, frac};
	endfunction

	task automatic random_item(int read_pct);
		logic [15:0] px;
		logic [15:0] py;
		px = random_coord(SAS_GRID_COLS);
		py = random_coord(SAS_GRID_ROWS);
		send_item(($urandom_range(99) < read_pct) ? MODE_READ : MODE_SPLAT, px, py,
			4'($urandom_range(15)), 4'($urandom_range(15)));
	endtask

	initial begin : stimulus
		int phase_items;
		int read_pct;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_COLOR_RED;
		cfg_data          = 8'h00;
		in_ch.valid       = 1'b0;
		in_ch.mode        = MODE_SPLAT;
		in_ch.pos_x       = 16'h0000;
		in_ch.pos_y       = 16'h0000;
		in_ch.read_column = 4'h0;
		in_ch.read_row    = 4'h0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items with the colour left white from reset.
		splat_at(16'h0000, 16'h0000);
		read_at(0, 0);
		splat_at(16'h0080, 16'h0080);
		read_at(0, 0);
		read_at(1, 0);
		read_at(0, 1);
		read_at(1, 1);
		// Splats partly and wholly off the grid.
		splat_at(16'h0FFF, 16'h0FFF);
		read_at(15, 15);
		splat_at(16'h0F40, 16'h0320);
		read_at(15, 3);
		splat_at(16'h0520, 16'h0FC0);
		read_at(5, 15);
		splat_at(16'hFFFF, 16'hFFFF);
		splat_at(16'h10FF, 16'h0000);
		splat_at(16'h0000, 16'h10FF);
		splat_at(16'h0E01, 16'h0E01);
		read_at(15, 0);
		read_at(0, 15);
		read_at(14, 14);
		// A second full-weight splat drives the corner pixel into saturation.
		splat_at(16'h0000, 16'h0000);
		read_at(0, 0);
		drain();

		for (int p = 0; p < 8; p++) begin
			phase_items = 125;
			read_pct = 40;
			case (p)
				0: begin
					set_colour(8'h00, 8'h00, 8'h00);
					phase_items = 60;
				end
				1: begin
					set_colour(CH_MAX, CH_MAX, CH_MAX);
					phase_items = 40;
				end
				2: begin
					set_colour(CH_MAX, 8'h00, 8'h01);
					phase_items = 40;
				end
				default: begin
					set_colour(8'($urandom_range(48)), 8'($urandom_range(48)),
						8'($urandom_range(48)));
				end
			endcase
			send_steady = (p == 4);
			take_steady = (p == 4);
			// The receiver holds off while mostly reads are offered, so the input stalls.
			if (p == 5) begin
				read_pct = 80;
				holds_asked++;
			end
			repeat (phase_items) random_item(read_pct);
			drain();
		end

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
